// ===== rtl/rc5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_pkg: shared types, constants and helpers for the RC5 block decryptor
// Word widths, key schedule constants, register indexes, the lane record
// that travels down the round pipeline, and the word rotators.
// ----------------------------------------------------------------------------
package rc5_pkg;

   localparam int WORD_W      = 32;
   localparam int ROT_W       = 5;
   localparam int KEY_WORDS   = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 4;
   localparam int ROUNDS_DEF  = 12;

   localparam logic [WORD_W-1:0] MAGIC_P     = 32'hB7E15163;
   localparam logic [WORD_W-1:0] MAGIC_Q_NEG = 32'h61C88647;
   localparam logic [ROT_W-1:0]  KEY_ROT     = 5'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 4'd1;

   // One item as it moves through the round stages
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] upd;
      logic [WORD_W-1:0] other;
   } rc5_lane_type;

   function automatic logic [WORD_W-1:0] rotl_word(input logic [WORD_W-1:0] x,
                                                   input logic [ROT_W-1:0]  r);
      logic [2*WORD_W-1:0] t;
      t = {x, x} << r;
      return t[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] rotr_word(input logic [WORD_W-1:0] x,
                                                   input logic [ROT_W-1:0]  r);
      logic [2*WORD_W-1:0] t;
      t = {x, x} >> r;
      return t[WORD_W-1:0];
   endfunction

   // Initial subkey n: P minus n times the negated Q constant
   function automatic logic [WORD_W-1:0] seed_word(input int n);
      logic [WORD_W-1:0] nn;
      nn = WORD_W'(n);
      return MAGIC_P - MAGIC_Q_NEG * nn;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rc5_round_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_round_stage: one registered half round
// Subtracts the subkey from the updated word, rotates it right by the other
// word and XORs the other word in. The pair leaves swapped, so the next
// stage updates the other word with the same logic.
// ----------------------------------------------------------------------------
module rc5_round_stage
   import rc5_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rc5_lane_type      lane_in,
   input  wire logic [WORD_W-1:0] subkey,
   output rc5_lane_type           lane_out
);

   logic              valid_ff;
   logic              valid_in;
   logic [WORD_W-1:0] upd_ff;
   logic [WORD_W-1:0] upd_in;
   logic [WORD_W-1:0] other_ff;
   logic [WORD_W-1:0] other_in;

   // Half-round mix, then swap the pair
   always_comb begin
      valid_in = lane_in.valid;
      upd_in   = lane_in.other;
      other_in = rotr_word(lane_in.upd - subkey, lane_in.other[ROT_W-1:0]) ^ lane_in.other;
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the words of the item
   always_ff @(posedge clock) begin
      upd_ff   <= upd_in;
      other_ff <= other_in;
   end

   assign lane_out = '{valid: valid_ff, upd: upd_ff, other: other_ff};

endmodule
`default_nettype wire

// ===== rtl/rc5_key_expand.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_key_expand: key registers and subkey schedule
// Holds the two key halves, and after reset or a key write seeds the subkey
// ring and runs the mixing steps, each as half step A then half step B, on
// the heads of a rotating subkey ring and a rotating key word ring.
// ----------------------------------------------------------------------------
module rc5_key_expand
   import rc5_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEF
)
(
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]                  csr_index,
   input  wire logic [CSR_DATA_W-1:0]                   csr_wdata,
   output logic [2*ROUNDS+1:0][WORD_W-1:0]              subkey,
   output logic                                         busy
);

   localparam int TABLE_WORDS = 2 * ROUNDS + 2;
   localparam int MIX_STEPS   = 3 * TABLE_WORDS;
   localparam int STEP_W      = $clog2(MIX_STEPS);

   typedef enum logic [3:0] {
      ST_SEED  = 4'b0001,
      ST_MIX_A = 4'b0010,
      ST_MIX_B = 4'b0100,
      ST_IDLE  = 4'b1000
   } rc5_kx_state_type;

   rc5_kx_state_type                      state_ff;
   rc5_kx_state_type                      state_in;
   logic [STEP_W-1:0]                     step_ff;
   logic [STEP_W-1:0]                     step_in;
   logic [CSR_DATA_W-1:0]                 key_low_ff;
   logic [CSR_DATA_W-1:0]                 key_low_in;
   logic [CSR_DATA_W-1:0]                 key_high_ff;
   logic [CSR_DATA_W-1:0]                 key_high_in;
   logic [WORD_W-1:0]                     a_ff;
   logic [WORD_W-1:0]                     a_in;
   logic [WORD_W-1:0]                     b_ff;
   logic [WORD_W-1:0]                     b_in;
   logic [TABLE_WORDS-1:0][WORD_W-1:0]    table_ff;
   logic [TABLE_WORDS-1:0][WORD_W-1:0]    table_in;
   logic [KEY_WORDS-1:0][WORD_W-1:0]      scratch_ff;
   logic [KEY_WORDS-1:0][WORD_W-1:0]      scratch_in;
   logic                                  key_write;
   logic [WORD_W-1:0]                     mix_a;
   logic [WORD_W-1:0]                     ab_sum;
   logic [WORD_W-1:0]                     mix_b;

   // Decode key writes; other indexes are dropped
   always_comb begin
      key_write   = 1'b0;
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we && (csr_index == CSR_KEY_LOW)) begin
         key_write  = 1'b1;
         key_low_in = csr_wdata;
      end
      if (csr_we && (csr_index == CSR_KEY_HIGH)) begin
         key_write   = 1'b1;
         key_high_in = csr_wdata;
      end
   end

   // Mixing arithmetic on the ring heads
   always_comb begin
      mix_a  = rotl_word(table_ff[0] + a_ff + b_ff, KEY_ROT);
      ab_sum = a_ff + b_ff;
      mix_b  = rotl_word(scratch_ff[0] + ab_sum, ab_sum[ROT_W-1:0]);
   end

   // Sequence the schedule: seed, then half steps A and B
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      table_in   = table_ff;
      scratch_in = scratch_ff;
      case (state_ff)
         ST_SEED: begin
            for (int i = 0; i < TABLE_WORDS; i++) begin
               table_in[i] = seed_word(i);
            end
            scratch_in[0] = key_low_ff[WORD_W-1:0];
            scratch_in[1] = key_low_ff[CSR_DATA_W-1:WORD_W];
            scratch_in[2] = key_high_ff[WORD_W-1:0];
            scratch_in[3] = key_high_ff[CSR_DATA_W-1:WORD_W];
            a_in     = '0;
            b_in     = '0;
            step_in  = '0;
            state_in = ST_MIX_A;
         end
         ST_MIX_A: begin
            a_in        = mix_a;
            table_in[0] = mix_a;
            state_in    = ST_MIX_B;
         end
         ST_MIX_B: begin
            b_in = mix_b;
            // rotate both rings by one word
            for (int i = 0; i < TABLE_WORDS - 1; i++) begin
               table_in[i] = table_ff[i+1];
            end
            table_in[TABLE_WORDS-1] = table_ff[0];
            for (int i = 0; i < KEY_WORDS - 1; i++) begin
               scratch_in[i] = scratch_ff[i+1];
            end
            scratch_in[KEY_WORDS-1] = mix_b;
            if (step_ff == STEP_W'(MIX_STEPS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MIX_A;
            end
         end
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_SEED;
         end
      endcase
      if (key_write) begin
         state_in = ST_SEED;
      end
   end

   // Control and key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SEED;
         step_ff     <= '0;
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   // Schedule data path
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      table_ff   <= table_in;
      scratch_ff <= scratch_in;
   end

   assign subkey = table_ff;
   assign busy   = (state_ff != ST_IDLE);

   // A key write restarts the schedule
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      key_write |=> (state_ff == ST_SEED))
      else $error("key write did not restart the schedule");

   // Seeding is followed by the first half step
   a_seed_then_mix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED) && !key_write |=> (state_ff == ST_MIX_A))
      else $error("seed not followed by mixing");

   // Half step B only follows half step A
   a_b_after_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_B) |-> ($past(state_ff) == ST_MIX_A))
      else $error("mix half B without half A");

endmodule
`default_nettype wire

// ===== rtl/rc5_block_decrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc5_block_decrypt: RC5-32 block decryptor, ECB mode
// Key registers, subkey schedule and a fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// After reset and after every write to a key register the block expands the
// key and holds busy high while the schedule runs: it seeds the subkey ring,
// then runs each mixing step as half step A and half step B. While busy is
// low an item is taken on every cycle that start is high. Each item passes
// 2*ROUNDS half-round stages and one final subtract stage, so its result
// appears on rsp_valid and the rsp_ words for a single cycle; the receiver
// cannot hold results off, so it must take every strobe. Write the key only
// while no item is in flight.
// ----------------------------------------------------------------------------
module rc5_block_decrypt
   import rc5_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [WORD_W-1:0]      req_left_word,
   input  wire logic [WORD_W-1:0]      req_right_word,
   output logic                        rsp_valid,
   output logic [WORD_W-1:0]           rsp_plain_left,
   output logic [WORD_W-1:0]           rsp_plain_right,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TABLE_WORDS = 2 * ROUNDS + 2;
   localparam int STAGES      = 2 * ROUNDS;
   localparam int LATENCY     = STAGES + 1;

   logic [TABLE_WORDS-1:0][WORD_W-1:0] subkey;
   rc5_lane_type                       lane [STAGES+1];
   logic                               req_fire;
   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic [WORD_W-1:0]                  plain_left_ff;
   logic [WORD_W-1:0]                  plain_left_in;
   logic [WORD_W-1:0]                  plain_right_ff;
   logic [WORD_W-1:0]                  plain_right_in;

   rc5_key_expand #(
      .ROUNDS (ROUNDS)
   ) u_key_expand (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .subkey    (subkey),
      .busy      (busy)
   );

   // Take an item when idle; the right word is updated first
   assign req_fire = start && !busy;
   assign lane[0]  = '{valid: req_fire, upd: req_right_word, other: req_left_word};

   // Half-round stages, last round first
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      rc5_round_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lane[k]),
         .subkey   (subkey[TABLE_WORDS-1-k]),
         .lane_out (lane[k+1])
      );
   end

   // Subtract the first two subkeys
   always_comb begin
      out_valid_in   = lane[STAGES].valid;
      plain_left_in  = lane[STAGES].other - subkey[0];
      plain_right_in = lane[STAGES].upd - subkey[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plain_left_ff  <= plain_left_in;
      plain_right_ff <= plain_right_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_plain_left  = plain_left_ff;
   assign rsp_plain_right = plain_right_ff;

   // Every result traces back to an item taken earlier
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_fire, LATENCY))
      else $error("result without a matching item");

   // Every item taken produces a result
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##LATENCY rsp_valid)
      else $error("item produced no result");

   // No item enters while the schedule runs
   a_no_fire_busy: assert property (@(posedge clock) disable iff (reset)
      lane[0].valid |-> !busy)
      else $error("item taken during key expansion");

endmodule
`default_nettype wire

// ===== bench/rc5_decrypt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_decrypt_checker: scoreboard for the RC5-32 block decryptor
// Tracks the key registers and rebuilds the subkey schedule on every key
// write and at reset. Computes the plaintext for each block that is taken
// and compares each result strobe, field by field, against the oldest
// outstanding plaintext.
// ----------------------------------------------------------------------------
module rc5_decrypt_checker
   import rc5_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [WORD_W-1:0]      req_left_word,
   input  logic [WORD_W-1:0]      req_right_word,
   input  logic                   rsp_valid,
   input  logic [WORD_W-1:0]      rsp_plain_left,
   input  logic [WORD_W-1:0]      rsp_plain_right,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     blocks_pending,
   output int                     blocks_checked
);

   localparam int SUBKEYS     = 2 * ROUNDS + 2;
   localparam int MIX_STEPS   = 3 * SUBKEYS;
   localparam int MAX_REPORTS = 200;

   typedef struct {
      bit [WORD_W-1:0] left;
      bit [WORD_W-1:0] right;
   } plain_block_type;

   bit [CSR_DATA_W-1:0] key_lo_reg;
   bit [CSR_DATA_W-1:0] key_hi_reg;
   bit [WORD_W-1:0]     subkey [SUBKEYS];
   plain_block_type     plain_q [$];
   int                  errors  = 0;
   int                  checked = 0;

   function automatic bit [WORD_W-1:0] rot_left(bit [WORD_W-1:0] x, bit [ROT_W-1:0] n);
      if (n == 0) return x;
      return (x << n) | (x >> (WORD_W - int'(n)));
   endfunction

   function automatic bit [WORD_W-1:0] rot_right(bit [WORD_W-1:0] x, bit [ROT_W-1:0] n);
      if (n == 0) return x;
      return (x >> n) | (x << (WORD_W - int'(n)));
   endfunction

   // Rebuild the subkey schedule from the current key registers
   function automatic void build_subkeys();
      bit [WORD_W-1:0] mix_key [KEY_WORDS];
      bit [WORD_W-1:0] sum_a;
      bit [WORD_W-1:0] sum_b;
      bit [WORD_W-1:0] amount;
      int              si;
      int              ki;
      int              n;
      mix_key[0] = key_lo_reg[31:0];
      mix_key[1] = key_lo_reg[63:32];
      mix_key[2] = key_hi_reg[31:0];
      mix_key[3] = key_hi_reg[63:32];
      subkey[0] = MAGIC_P;
      for (n = 1; n < SUBKEYS; n++) subkey[n] = subkey[n-1] - MAGIC_Q_NEG;
      sum_a = '0;
      sum_b = '0;
      si    = 0;
      ki    = 0;
      for (n = 0; n < MIX_STEPS; n++) begin
         subkey[si]  = rot_left(subkey[si] + sum_a + sum_b, KEY_ROT);
         sum_a       = subkey[si];
         si          = (si + 1) % SUBKEYS;
         amount      = sum_a + sum_b;
         mix_key[ki] = rot_left(mix_key[ki] + sum_a + sum_b, amount[ROT_W-1:0]);
         sum_b       = mix_key[ki];
         ki          = (ki + 1) % KEY_WORDS;
      end
   endfunction

   // Run the rounds backward, then strip the first two subkeys
   function automatic plain_block_type decrypt_block(bit [WORD_W-1:0] ct_left,
                                                     bit [WORD_W-1:0] ct_right);
      plain_block_type pt;
      bit [WORD_W-1:0] ld;
      bit [WORD_W-1:0] rd;
      int              j;
      ld = ct_left;
      rd = ct_right;
      for (j = ROUNDS; j >= 1; j--) begin
         rd = rot_right(rd - subkey[2*j+1], ld[ROT_W-1:0]) ^ ld;
         ld = rot_right(ld - subkey[2*j], rd[ROT_W-1:0]) ^ rd;
      end
      pt.left  = ld - subkey[0];
      pt.right = rd - subkey[1];
      return pt;
   endfunction

   function automatic void note_failure(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s", msg);
   endfunction

   // Watch all three ports on every rising edge
   always @(posedge clock) begin : watch
      plain_block_type want;
      if (reset) begin
         key_lo_reg = '0;
         key_hi_reg = '0;
         build_subkeys();
         plain_q.delete();
      end else begin
         // compare the result strobe against the oldest plaintext
         if (rsp_valid) begin
            if (plain_q.size() == 0) begin
               note_failure($sformatf("result with no block outstanding: %h %h",
                                      rsp_plain_left, rsp_plain_right));
            end else begin
               want = plain_q.pop_front();
               checked++;
               if (rsp_plain_left !== want.left)
                  note_failure($sformatf("plain_left mismatch: expected %h, got %h",
                                         want.left, rsp_plain_left));
               if (rsp_plain_right !== want.right)
                  note_failure($sformatf("plain_right mismatch: expected %h, got %h",
                                         want.right, rsp_plain_right));
            end
         end
         // track key writes; other indexes are dropped
         if (csr_we) begin
            if (csr_index == CSR_KEY_LOW) begin
               key_lo_reg = csr_wdata;
               build_subkeys();
            end else if (csr_index == CSR_KEY_HIGH) begin
               key_hi_reg = csr_wdata;
               build_subkeys();
            end
         end
         // predict the plaintext of a block taken at this edge
         if (start && !busy)
            plain_q.push_back(decrypt_block(req_left_word, req_right_word));
      end
      blocks_pending <= plain_q.size();
      fail_count     <= errors;
      blocks_checked <= checked;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for rc5_block_decrypt
// Drives cipher blocks and key writes with random gaps and bursts, lets the
// checker predict and compare every plaintext, and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
   import rc5_pkg::*;

   localparam int LIMIT        = 200000;
   localparam int DRAIN_CYCLES = 2 * ROUNDS_DEF + 8;
   localparam int PHASE_BLOCKS = 120;

   // Indexes outside the register map; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 4'd15;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [WORD_W-1:0]      req_left_word  = '0;
   logic [WORD_W-1:0]      req_right_word = '0;
   logic                   rsp_valid;
   logic [WORD_W-1:0]      rsp_plain_left;
   logic [WORD_W-1:0]      rsp_plain_right;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int blocks_pending;
   int blocks_checked;
   int cycle_count  = 0;
   int blocks_sent  = 0;
   int key_writes   = 0;
   int dropped_writes = 0;
   bit burst_mode   = 1'b0;

   always #2 clock = ~clock;

   rc5_block_decrypt dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_left_word   (req_left_word),
      .req_right_word  (req_right_word),
      .rsp_valid       (rsp_valid),
      .rsp_plain_left  (rsp_plain_left),
      .rsp_plain_right (rsp_plain_right),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   rc5_decrypt_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_left_word   (req_left_word),
      .req_right_word  (req_right_word),
      .rsp_valid       (rsp_valid),
      .rsp_plain_left  (rsp_plain_left),
      .rsp_plain_right (rsp_plain_right),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .blocks_pending  (blocks_pending),
      .blocks_checked  (blocks_checked)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Mostly random words, with a share of all-zero, all-one and one-hot
   function automatic logic [WORD_W-1:0] pick_word();
      int sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_key();
      return {pick_word(), pick_word()};
   endfunction

   // Offer one block, hold it until taken, then idle for a random gap outside burst mode
   task automatic send_block(input logic [WORD_W-1:0] ct_left,
                             input logic [WORD_W-1:0] ct_right);
      int gap;
      start          <= 1'b1;
      req_left_word  <= ct_left;
      req_right_word <= ct_right;
      do @(posedge clock); while (busy);
      blocks_sent++;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         start          <= 1'b0;
         req_left_word  <= $urandom();
         req_right_word <= $urandom();
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and wait until every block in flight has come out
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register while the pipeline is empty
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      key_writes++;
      if (idx != CSR_KEY_LOW && idx != CSR_KEY_HIGH) dropped_writes++;
   endtask

   // Random blocks, switching between gapped traffic and back-to-back bursts
   task automatic send_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         send_block(pick_word(), pick_word());
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      int phase;
      int sel;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset (all-zero) key
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h0000_0000, 32'hFFFF_FFFF);
      send_block(32'hFFFF_FFFF, 32'h0000_0000);
      send_block(32'h8000_0000, 32'h0000_0001);
      send_block(32'h0000_0001, 32'h8000_0000);
      send_block(32'h0000_0020, 32'h0000_0040);
      send_block(32'hAAAA_AAAA, 32'h5555_5555);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);
      send_block(32'hB7E1_5163, 32'h61C8_8647);

      // Extreme keys: all ones in both halves
      write_csr(CSR_KEY_LOW, '1);
      write_csr(CSR_KEY_HIGH, '1);
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h7FFF_FFFF, 32'h8000_0000);
      send_block(32'h0000_001F, 32'hFFFF_FFE0);
      send_random(40);

      // Writes outside the register map must leave the key alone
      write_csr(CSR_UNMAPPED_LO, pick_key());
      write_csr(CSR_UNMAPPED_HI, '1);
      send_random(40);

      // Change one half only; the other keeps its value
      write_csr(CSR_KEY_LOW, '0);
      send_random(40);
      write_csr(CSR_KEY_HIGH, '0);
      write_csr(CSR_KEY_LOW, 64'h0000_0000_0000_0001);
      send_random(40);

      // Random key settings, sometimes one half, sometimes both
      for (phase = 0; phase < 8; phase++) begin
         sel = $urandom_range(0, 2);
         if (sel != 1) write_csr(CSR_KEY_LOW, pick_key());
         if (sel != 0) write_csr(CSR_KEY_HIGH, pick_key());
         send_random(PHASE_BLOCKS);
      end

      settle();
      $display("Run covered %0d cipher blocks under %0d register writes (%0d unmapped).",
               blocks_sent, key_writes, dropped_writes);
      $display("Plaintext results compared: %0d, failures: %0d.",
               blocks_checked, fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
